// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BPH_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bph_pkg.sv =====
// Shared types, constants and helper functions of the binned pixel histogram.
`default_nettype none

package bph_pkg;

    localparam int MAX_BINS_DEF   = 256;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF = 24;

    // Fixed field widths.
    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 8;
    localparam int BINS_W    = 9;
    localparam int CFG_IDX_W = 2;

    // Register reset values.
    localparam logic [BINS_W-1:0] BINS_RESET = 9'd255;
    localparam int UPPER_RESET = 255;

    // Depth of the queue between front and back end (a power of two).
    localparam int Q_DEPTH = 2;

    typedef enum logic [CMD_W-1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER = 2'd0,
        CFG_UPPER = 2'd1,
        CFG_BINS  = 2'd2
    } cfg_idx_t;

    // Control part of one classified operation.
    typedef struct packed {
        op_t  op;
        logic hit;
    } ctl_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bph_cfg.sv =====
// Configuration registers and the shared iterative divider that derives step and reciprocal.
`default_nettype none

module bph_cfg #(
    parameter int MAX_BINS   = bph_pkg::MAX_BINS_DEF,
    parameter int PIXEL_BITS = bph_pkg::PIXEL_BITS_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   cfg_valid,
    output logic                                                   cfg_ready,
    input  logic [bph_pkg::CFG_IDX_W-1:0]                          cfg_index,
    input  logic [bph_pkg::imax(PIXEL_BITS, bph_pkg::BINS_W)-1:0]  cfg_data,
    input  logic                                                   front_busy,
    output logic                                                   busy,
    output logic [PIXEL_BITS-1:0]                                  lower,
    output logic [PIXEL_BITS-1:0]                                  upper,
    output logic [PIXEL_BITS-1:0]                                  step,
    output logic [2*PIXEL_BITS:0]                                  recip,
    output logic [bph_pkg::BINS_W-1:0]                             bins_used
);
    import bph_pkg::*;

    localparam int DW = imax(2 * PIXEL_BITS, BINS_W);
    localparam int CW = $clog2(DW + 1);
    localparam int RW = 2 * PIXEL_BITS + 1;
    localparam logic [DW-1:0] RECIP_DIVIDEND = DW'({(2 * PIXEL_BITS){1'b1}});

    typedef enum logic [4:0] {
        ST_IDLE       = 5'b00001,
        ST_LOAD_STEP  = 5'b00010,
        ST_DIV_STEP   = 5'b00100,
        ST_LOAD_RECIP = 5'b01000,
        ST_DIV_RECIP  = 5'b10000
    } st_t;

    st_t                    state_reg, state_next;
    logic [PIXEL_BITS-1:0]  lower_reg, lower_next;
    logic [PIXEL_BITS-1:0]  upper_reg, upper_next;
    logic [BINS_W-1:0]      bins_reg, bins_next;
    logic [PIXEL_BITS-1:0]  step_reg, step_next;
    logic [RW-1:0]          recip_reg, recip_next;
    logic [DW-1:0]          quot_reg, quot_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [DW-1:0]          div_reg, div_next;
    logic [CW-1:0]          cnt_reg, cnt_next;

    logic                   wr;
    logic [PIXEL_BITS-1:0]  span;
    logic [PIXEL_BITS-1:0]  step_value;
    logic [DW:0]            rem_sh;
    logic [DW:0]            diff;
    logic                   take;
    logic [DW-1:0]          quot_step;

    assign cfg_ready = (state_reg == ST_IDLE) && !front_busy;
    assign busy      = (state_reg != ST_IDLE);
    assign wr        = cfg_valid && cfg_ready;
    assign lower     = lower_reg;
    assign upper     = upper_reg;
    assign step      = step_reg;
    assign recip     = recip_reg;

    // Bins in use: zero means one bin, anything above the store depth is clipped.
    always_comb
    begin
        if (bins_reg == '0)
        begin
            bins_used = BINS_W'(1);
        end
        else if (32'(bins_reg) > 32'(MAX_BINS))
        begin
            bins_used = BINS_W'(MAX_BINS);
        end
        else
        begin
            bins_used = bins_reg;
        end
    end

    assign span       = (upper_reg >= lower_reg) ? (upper_reg - lower_reg) : '0;
    assign step_value = (quot_reg == '0) ? PIXEL_BITS'(1) : quot_reg[PIXEL_BITS-1:0];

    // One restoring division step per cycle.
    assign rem_sh    = {rem_reg, quot_reg[DW-1]};
    assign diff      = rem_sh - {1'b0, div_reg};
    assign take      = !diff[DW];
    assign quot_step = {quot_reg[DW-2:0], take};

    always_comb
    begin
        state_next = state_reg;
        lower_next = lower_reg;
        upper_next = upper_reg;
        bins_next  = bins_reg;
        step_next  = step_reg;
        recip_next = recip_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (wr)
                begin
                    case (cfg_index)
                        CFG_LOWER:
                        begin
                            lower_next = cfg_data[PIXEL_BITS-1:0];
                            state_next = ST_LOAD_STEP;
                        end
                        CFG_UPPER:
                        begin
                            upper_next = cfg_data[PIXEL_BITS-1:0];
                            state_next = ST_LOAD_STEP;
                        end
                        CFG_BINS:
                        begin
                            bins_next  = cfg_data[BINS_W-1:0];
                            state_next = ST_LOAD_STEP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD_STEP:
            begin
                quot_next  = DW'(span);
                rem_next   = '0;
                div_next   = DW'(bins_used);
                cnt_next   = '0;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                rem_next  = take ? diff[DW-1:0] : rem_sh[DW-1:0];
                quot_next = quot_step;
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                begin
                    state_next = ST_LOAD_RECIP;
                end
            end
            ST_LOAD_RECIP:
            begin
                step_next  = step_value;
                quot_next  = RECIP_DIVIDEND;
                rem_next   = '0;
                div_next   = DW'(step_value);
                cnt_next   = '0;
                state_next = ST_DIV_RECIP;
            end
            ST_DIV_RECIP:
            begin
                rem_next  = take ? diff[DW-1:0] : rem_sh[DW-1:0];
                quot_next = quot_step;
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                begin
                    // Ceiling of 2^(2P) / step, exact for every pixel offset.
                    recip_next = {1'b0, quot_step[2*PIXEL_BITS-1:0]} + RW'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lower_reg <= '0;
            upper_reg <= PIXEL_BITS'(UPPER_RESET);
            bins_reg  <= BINS_RESET;
            step_reg  <= PIXEL_BITS'(1);
            recip_reg <= RW'(1) << (2 * PIXEL_BITS);
        end
        else
        begin
            state_reg <= state_next;
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            bins_reg  <= bins_next;
            step_reg  <= step_next;
            recip_reg <= recip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        cnt_reg  <= cnt_next;
    end

endmodule

`default_nettype wire

// ===== rtl/bph_front.sv =====
// Front end: accepts commands, maps pixels to bins and computes read edges.
`default_nettype none

module bph_front #(
    parameter int MAX_BINS   = bph_pkg::MAX_BINS_DEF,
    parameter int PIXEL_BITS = bph_pkg::PIXEL_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bph_pkg::CMD_W-1:0]         cmd,
    input  logic [PIXEL_BITS-1:0]             pixel,
    input  logic [bph_pkg::INDEX_W-1:0]       bin_index,
    input  logic                              cfg_busy,
    input  logic [PIXEL_BITS-1:0]             lower,
    input  logic [PIXEL_BITS-1:0]             upper,
    input  logic [PIXEL_BITS-1:0]             step,
    input  logic [2*PIXEL_BITS:0]             recip,
    input  logic [bph_pkg::BINS_W-1:0]        bins_used,
    output logic                              front_busy,
    output logic                              push_valid,
    input  logic                              push_ready,
    output bph_pkg::ctl_t                     push_ctl,
    output logic [$clog2(MAX_BINS)-1:0]       push_addr,
    output logic [PIXEL_BITS-1:0]             push_edge
);
    import bph_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int MA = imax(PIXEL_BITS, INDEX_W);
    localparam int MB = 2 * PIXEL_BITS + 1;
    localparam int PW = MA + MB;
    localparam int IW = imax(PIXEL_BITS, BINS_W);

    logic                   s1_valid_reg;
    op_t                    s1_op_reg;
    logic [PW-1:0]          s1_prod_reg;
    logic [INDEX_W-1:0]     s1_idx_reg;

    logic                   accept;
    logic                   fire;
    logic                   keep;
    logic                   is_read;
    logic [PIXEL_BITS-1:0]  offset;
    logic [MA-1:0]          mul_a;
    logic [MB-1:0]          mul_b;
    logic [PW-1:0]          product;
    logic [PIXEL_BITS-1:0]  quot;
    logic [IW-1:0]          n_ext;
    logic [IW-1:0]          q_ext;
    logic [IW-1:0]          i_ext;
    logic [IW-1:0]          bin_sel;

    assign in_ready   = !cfg_busy && (!s1_valid_reg || push_ready);
    assign accept     = in_valid && in_ready;
    assign fire       = s1_valid_reg && push_ready;
    assign front_busy = s1_valid_reg;
    assign push_valid = s1_valid_reg;

    // Pixels below the range count in bin 0, so their offset is forced to zero.
    assign offset  = (pixel < lower) ? '0 : (pixel - lower);
    assign is_read = (cmd == OP_READ);

    // One shared multiplier: pixel offset times reciprocal, or bin index times step.
    assign mul_a   = is_read ? MA'(bin_index) : MA'(offset);
    assign mul_b   = is_read ? MB'(step) : recip;
    assign product = PW'(mul_a) * PW'(mul_b);

    always_comb
    begin
        case (cmd)
            OP_ADD:   keep = !(pixel > upper);
            OP_CLEAR: keep = 1'b1;
            OP_READ:  keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= keep;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            s1_op_reg   <= op_t'(cmd);
            s1_prod_reg <= product;
            s1_idx_reg  <= bin_index;
        end
    end

    // Second step: quotient clamp to the last bin, read range check, edge sum.
    assign quot    = s1_prod_reg[2*PIXEL_BITS +: PIXEL_BITS];
    assign n_ext   = IW'(bins_used);
    assign q_ext   = IW'(quot);
    assign i_ext   = IW'(s1_idx_reg);
    assign bin_sel = (q_ext >= n_ext) ? (n_ext - IW'(1)) : q_ext;

    assign push_ctl.op  = s1_op_reg;
    assign push_ctl.hit = (i_ext < n_ext);
    assign push_addr    = (s1_op_reg == OP_READ) ? AW'(i_ext) : AW'(bin_sel);
    assign push_edge    = lower + s1_prod_reg[PIXEL_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/bph_queue.sv =====
// Short register queue that decouples the front end from the back end.
`default_nettype none

module bph_queue #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import bph_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bph_back.sv =====
// Back end: bin count memory with read-modify-write, clear and read-out register.
`default_nettype none

module bph_back #(
    parameter int MAX_BINS   = bph_pkg::MAX_BINS_DEF,
    parameter int PIXEL_BITS = bph_pkg::PIXEL_BITS_DEF,
    parameter int COUNT_BITS = bph_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  bph_pkg::ctl_t                 q_ctl,
    input  logic [$clog2(MAX_BINS)-1:0]   q_addr,
    input  logic [PIXEL_BITS-1:0]         q_edge,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COUNT_BITS-1:0]         bin_total,
    output logic [PIXEL_BITS-1:0]         bin_lower_edge,
    output logic                          bin_valid
);
    import bph_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] mem [MAX_BINS];
    logic [MAX_BINS-1:0]   vld_reg;

    logic                  ex_valid_reg;
    ctl_t                  ex_ctl_reg;
    logic [AW-1:0]         ex_addr_reg;
    logic [PIXEL_BITS-1:0] ex_edge_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic                  lw_valid_reg;
    logic [AW-1:0]         lw_addr_reg;
    logic [COUNT_BITS-1:0] lw_data_reg;

    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [PIXEL_BITS-1:0] edge_reg;
    logic                  hit_reg;

    logic                  out_free;
    logic                  ex_done;
    logic                  is_add;
    logic                  is_clr;
    logic                  out_load;
    logic                  fwd;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] wr_data;

    assign out_free = !out_valid_reg || out_ready;
    assign is_add   = ex_valid_reg && (ex_ctl_reg.op == OP_ADD);
    assign is_clr   = ex_valid_reg && (ex_ctl_reg.op == OP_CLEAR);
    assign out_load = ex_valid_reg && (ex_ctl_reg.op == OP_READ) && out_free;
    assign ex_done  = ex_valid_reg && ((ex_ctl_reg.op != OP_READ) || out_free);
    assign q_pop    = q_valid && (!ex_valid_reg || ex_done);

    // The memory read was registered as the operation entered this stage, so the last write is forwarded,
    // and an entry whose valid bit is clear reads as zero.
    assign fwd     = lw_valid_reg && (lw_addr_reg == ex_addr_reg);
    assign cur     = fwd ? lw_data_reg : (vld_reg[ex_addr_reg] ? rd_data_reg : '0);
    assign wr_data = (cur == COUNT_MAX) ? cur : (cur + COUNT_BITS'(1));

    always_ff @(posedge clk)
    begin
        if (is_add)
        begin
            mem[ex_addr_reg] <= wr_data;
        end
        if (q_pop)
        begin
            rd_data_reg <= mem[q_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            lw_valid_reg  <= 1'b0;
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (is_clr)
            begin
                vld_reg      <= '0;
                lw_valid_reg <= 1'b0;
            end
            else if (is_add)
            begin
                vld_reg[ex_addr_reg] <= 1'b1;
                lw_valid_reg         <= 1'b1;
            end
            if (q_pop)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (ex_done)
            begin
                ex_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ex_ctl_reg  <= q_ctl;
            ex_addr_reg <= q_addr;
            ex_edge_reg <= q_edge;
        end
        if (is_add)
        begin
            lw_addr_reg <= ex_addr_reg;
            lw_data_reg <= wr_data;
        end
        if (out_load)
        begin
            total_reg <= ex_ctl_reg.hit ? cur : '0;
            edge_reg  <= ex_ctl_reg.hit ? ex_edge_reg : '0;
            hit_reg   <= ex_ctl_reg.hit;
        end
    end

    assign out_valid      = out_valid_reg;
    assign bin_total      = total_reg;
    assign bin_lower_edge = edge_reg;
    assign bin_valid      = hit_reg;

endmodule

`default_nettype wire

// ===== rtl/binned_pixel_histogram_core.sv =====
// Top level of the binned pixel histogram: configuration, front end, queue and back end.
//
// Usage. Items arrive on the in channel (cmd, pixel, bin_index): add a pixel,
// clear all bins, or read one bin. Only a read gives a transfer on the out
// channel (bin_total, bin_lower_edge, bin_valid). Registers are written on the
// cfg channel (index 0 lower, 1 upper, 2 bin count; other indexes are ignored).
// Throughput is one item per cycle while the divider is idle and the out channel
// does not stall: the front end maps a pixel to its bin with one reciprocal
// multiply, and the back end does one read-modify-write per cycle on the count
// memory with write forwarding. A read result passes in turn through the front-end
// register, the queue, the back-end execute register and the output register.
// A write to a known register starts the divider in the configuration unit,
// which derives the step and its reciprocal; in_ready and cfg_ready stay low meanwhile.
// After reset all bins read as zero at once (per-bin valid bits), the step is
// one, and the registers hold lower 0, upper 255 and 255 bins.
// When the receiver stalls, the result holds in the output register, the
// back end stops at the next read, the queue fills, and in_ready then drops.
`default_nettype none
`include "assert_macros.svh"

module binned_pixel_histogram_core #(
    parameter int MAX_BINS   = bph_pkg::MAX_BINS_DEF,
    parameter int PIXEL_BITS = bph_pkg::PIXEL_BITS_DEF,
    parameter int COUNT_BITS = bph_pkg::COUNT_BITS_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   cfg_valid,
    output logic                                                   cfg_ready,
    input  logic [bph_pkg::CFG_IDX_W-1:0]                          cfg_index,
    input  logic [bph_pkg::imax(PIXEL_BITS, bph_pkg::BINS_W)-1:0]  cfg_data,
    input  logic                                                   in_valid,
    output logic                                                   in_ready,
    input  logic [bph_pkg::CMD_W-1:0]                              cmd,
    input  logic [PIXEL_BITS-1:0]                                  pixel,
    input  logic [bph_pkg::INDEX_W-1:0]                            bin_index,
    output logic                                                   out_valid,
    input  logic                                                   out_ready,
    output logic [COUNT_BITS-1:0]                                  bin_total,
    output logic [PIXEL_BITS-1:0]                                  bin_lower_edge,
    output logic                                                   bin_valid
);
    import bph_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int QW = $bits(ctl_t) + AW + PIXEL_BITS;

    // Configuration state seen by the front end.
    logic                  cfg_busy;
    logic                  front_busy;
    logic [PIXEL_BITS-1:0] lower;
    logic [PIXEL_BITS-1:0] upper;
    logic [PIXEL_BITS-1:0] step;
    logic [2*PIXEL_BITS:0] recip;
    logic [BINS_W-1:0]     bins_used;

    // Front end to queue.
    logic                  push_valid;
    logic                  push_ready;
    ctl_t                  push_ctl;
    logic [AW-1:0]         push_addr;
    logic [PIXEL_BITS-1:0] push_edge;

    // Queue to back end.
    logic                  q_valid;
    logic                  q_pop;
    logic [QW-1:0]         q_data;
    ctl_t                  q_ctl;
    logic [AW-1:0]         q_addr;
    logic [PIXEL_BITS-1:0] q_edge;

    bph_cfg #(
        .MAX_BINS   (MAX_BINS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .front_busy (front_busy),
        .busy       (cfg_busy),
        .lower      (lower),
        .upper      (upper),
        .step       (step),
        .recip      (recip),
        .bins_used  (bins_used)
    );

    bph_front #(
        .MAX_BINS   (MAX_BINS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .pixel      (pixel),
        .bin_index  (bin_index),
        .cfg_busy   (cfg_busy),
        .lower      (lower),
        .upper      (upper),
        .step       (step),
        .recip      (recip),
        .bins_used  (bins_used),
        .front_busy (front_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_ctl   (push_ctl),
        .push_addr  (push_addr),
        .push_edge  (push_edge)
    );

    // The queue carries finished operations: bin address, edge and control.
    bph_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_ctl, push_addr, push_edge}),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    assign {q_ctl, q_addr, q_edge} = q_data;

    bph_back #(
        .MAX_BINS   (MAX_BINS),
        .PIXEL_BITS (PIXEL_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_ctl          (q_ctl),
        .q_addr         (q_addr),
        .q_edge         (q_edge),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bin_total      (bin_total),
        .bin_lower_edge (bin_lower_edge),
        .bin_valid      (bin_valid)
    );

    // No item may enter while the step and reciprocal are being derived.
    `BPH_ASSERT_IMPLY(a_no_input_while_dividing, clk, rst_n, cfg_busy, !in_ready, "input taken during division")

    // A write to a known register always restarts the divider.
    `BPH_ASSERT_NEXT(a_write_starts_divider, clk, rst_n, cfg_valid && cfg_ready && (cfg_index == CFG_LOWER || cfg_index == CFG_UPPER || cfg_index == CFG_BINS), cfg_busy, "divider not started after register write")

    // The step never reaches zero, so the reciprocal stays defined.
    `BPH_ASSERT_IMPLY(a_step_nonzero, clk, rst_n, 1'b1, step != '0, "step is zero")

    // A read beyond the bins in use returns all-zero fields.
    `BPH_ASSERT_IMPLY(a_miss_is_zero, clk, rst_n, out_valid && !bin_valid, bin_total == '0 && bin_lower_edge == '0, "nonzero fields on invalid read")

endmodule

`default_nettype wire

// ===== tb/binned_pixel_histogram_core_tb.sv =====
// Self-checking testbench for the binned pixel histogram core.
`timescale 1ns / 1ps

module binned_pixel_histogram_core_tb;
    import bph_pkg::*;

    // Command code with no operation behind it; the block must swallow it silently.
    localparam logic [CMD_W-1:0] OP_UNUSED = 2'd3;
    // Register index past the last register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 100;
    // Cycles allowed to pass after the last read result, so that adds and clears
    // still in the pipeline have landed before a register write or the end.
    localparam int SETTLE_CYCLES   = 12;
    // Cycles without any transfer on any channel before the run is abandoned.
    // The longest quiet stretch in a correct run is a divider pass plus a settle
    // pause, so this is far above it.
    localparam int STALL_LIMIT     = 5000;

    // One read result: count, lower edge of the bin, and the in-range flag.
    typedef struct packed {
        logic [COUNT_BITS_DEF-1:0] total;
        logic [PIXEL_BITS_DEF-1:0] lower_edge;
        logic                      ok;
    } bin_report_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // One row of the directed script. For ROW_CFG, code is the register index and
    // value the write data; for ROW_ITEM, code is the command and value holds the
    // pixel. Where typed is set, want is the expected result written in the script.
    typedef struct packed {
        row_kind_t                 kind;
        logic [1:0]                code;
        logic [8:0]                value;
        logic [INDEX_W-1:0]        bin_sel;
        logic                      typed;
        bin_report_t               want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [8:0]            cfg_data = '0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      cmd = '0;
    logic [7:0]            pixel = '0;
    logic [INDEX_W-1:0]    bin_index = '0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [23:0]           bin_total;
    logic [7:0]            bin_lower_edge;
    logic                  bin_valid;

    // When set, neither the sender nor the receiver inserts any idle cycle.
    logic                  calm = 1'b0;

    int                    mismatches = 0;
    int                    quiet_cycles = 0;

    // Shadow copy of the block's state, kept by the prediction functions below.
    logic [7:0]            shadow_lower;
    logic [7:0]            shadow_upper;
    logic [8:0]            shadow_bins;
    logic [7:0]            shadow_step;
    logic [23:0]           shadow_tally [256];

    bin_report_t           pending_reports [$];
    script_row_t           script [$];

    binned_pixel_histogram_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .pixel          (pixel),
        .bin_index      (bin_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bin_total      (bin_total),
        .bin_lower_edge (bin_lower_edge),
        .bin_valid      (bin_valid)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction of the histogram.
    // ------------------------------------------------------------------

    // Number of bins actually in use: a zero register means one bin, and anything
    // past the store depth is clipped to the store depth.
    function automatic int unsigned bins_in_use();
        if (shadow_bins == 9'd0)
            return 1;
        if (shadow_bins > 9'd256)
            return 256;
        return shadow_bins;
    endfunction

    // Bin width from the current range. An inverted range counts as an empty
    // span, and a width that would come out as zero is raised to one.
    function automatic void recompute_step();
        int unsigned span;
        int unsigned width;
        span = (shadow_upper >= shadow_lower) ? (shadow_upper - shadow_lower) : 0;
        width = span / bins_in_use();
        shadow_step = (width == 0) ? 8'd1 : width[7:0];
    endfunction

    function automatic void shadow_reset();
        foreach (shadow_tally[i])
            shadow_tally[i] = '0;
        shadow_lower = 8'd0;
        shadow_upper = UPPER_RESET[7:0];
        shadow_bins  = BINS_RESET;
        recompute_step();
    endfunction

    // A register write. Lower and upper keep only the pixel bits of the data.
    function automatic void shadow_write(input logic [1:0] idx, input logic [8:0] data);
        if (idx == CFG_LOWER)
            shadow_lower = data[7:0];
        else if (idx == CFG_UPPER)
            shadow_upper = data[7:0];
        else if (idx == CFG_BINS)
            shadow_bins = data;
        else
            return;
        recompute_step();
    endfunction

    // Applies one input item to the shadow state. Returns 1 and fills rep when
    // the item is a read, which is the only command that answers.
    function automatic bit shadow_apply(input logic [1:0] code, input logic [7:0] pix,
                                        input logic [7:0] sel, output bin_report_t rep);
        int unsigned slot;
        int unsigned lanes;
        rep = '0;
        lanes = bins_in_use();
        if (code == OP_ADD) begin
            // Above the range the pixel is dropped; below it, it lands in bin 0.
            if (pix > shadow_upper)
                return 0;
            slot = (pix < shadow_lower) ? 0 : (pix - shadow_lower) / shadow_step;
            // The top few in-range values can overshoot the last bin; they fold in.
            if (slot >= lanes)
                slot = lanes - 1;
            if (shadow_tally[slot] != 24'hFF_FFFF)
                shadow_tally[slot] = shadow_tally[slot] + 24'd1;
            return 0;
        end
        if (code == OP_CLEAR) begin
            foreach (shadow_tally[i])
                shadow_tally[i] = '0;
            return 0;
        end
        if (code == OP_READ) begin
            if (sel < lanes) begin
                rep.total      = shadow_tally[sel];
                rep.lower_edge = shadow_lower + sel * shadow_step;
                rep.ok         = 1'b1;
            end
            return 1;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Every task is entered just after a rising edge and returns just
    // after one, so each signal gets at most one nonblocking update per step.
    // ------------------------------------------------------------------

    // Sends one item on the in channel and records the result it should give.
    // A typed row overrides the prediction with the value written in the script.
    task automatic send_pixel_cmd(input logic [1:0] code, input logic [7:0] pix,
                                  input logic [7:0] sel, input logic typed,
                                  input bin_report_t want);
        bin_report_t rep;
        bit answers;
        while (!calm && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= code;
        pixel     <= pix;
        bin_index <= sel;
        answers = shadow_apply(code, pix, sel, rep);
        if (answers)
            pending_reports.push_back(typed ? want : rep);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Lets the block go idle: stop sending, wait for every read result, then give
    // adds and clears still in flight time to retire.
    task automatic let_block_settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write on the cfg channel. The block keeps cfg_ready low while
    // its divider derives the new step, so the transfer waits for it.
    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_write(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: mostly ready, with short random stalls outside calm stretches.
    always @(posedge clk)
    begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
    end

    // ------------------------------------------------------------------
    // Result checking: every read transfer is matched against the oldest
    // outstanding expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : report_check
        bin_report_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: read result with nothing expected: total=%0d edge=%0d valid=%0b",
                         $time, bin_total, bin_lower_edge, bin_valid);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                if (bin_total !== want.total) begin
                    $display("%0t: bin_total expected %0d actual %0d",
                             $time, want.total, bin_total);
                    mismatches++;
                end
                if (bin_lower_edge !== want.lower_edge) begin
                    $display("%0t: bin_lower_edge expected %0d actual %0d",
                             $time, want.lower_edge, bin_lower_edge);
                    mismatches++;
                end
                if (bin_valid !== want.ok) begin
                    $display("%0t: bin_valid expected %0b actual %0b",
                             $time, want.ok, bin_valid);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no channel completes a transfer.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed script.
    // ------------------------------------------------------------------
    function automatic void add_item(input logic [1:0] code, input logic [7:0] pix,
                                     input logic [7:0] sel);
        script_row_t r;
        r = '0;
        r.kind    = ROW_ITEM;
        r.code    = code;
        r.value   = {1'b0, pix};
        r.bin_sel = sel;
        script.push_back(r);
    endfunction

    function automatic void add_typed_read(input logic [7:0] sel, input logic [23:0] total,
                                           input logic [7:0] lower_edge, input logic ok);
        script_row_t r;
        r = '0;
        r.kind    = ROW_ITEM;
        r.code    = OP_READ;
        r.bin_sel = sel;
        r.typed   = 1'b1;
        r.want    = '{total: total, lower_edge: lower_edge, ok: ok};
        script.push_back(r);
    endfunction

    function automatic void add_write(input logic [1:0] idx, input logic [8:0] data);
        script_row_t r;
        r = '0;
        r.kind  = ROW_CFG;
        r.code  = idx;
        r.value = data;
        script.push_back(r);
    endfunction

    function automatic void build_script();
        // Reset state: 255 bins of width one, all empty; bin 255 is past the end.
        add_typed_read(8'd0,   24'd0, 8'd0,   1'b1);
        add_typed_read(8'd255, 24'd0, 8'd0,   1'b0);
        add_typed_read(8'd254, 24'd0, 8'd254, 1'b1);
        // Pixel extremes; 255 overshoots the last bin and folds into bin 254.
        add_item(OP_ADD, 8'd0,   8'd0);
        add_item(OP_ADD, 8'd255, 8'd0);
        add_item(OP_ADD, 8'd254, 8'd0);
        add_item(OP_ADD, 8'd128, 8'd0);
        add_item(OP_READ, 8'd0, 8'd254);
        add_item(OP_READ, 8'd0, 8'd0);
        // The unused command must neither count nor answer.
        add_item(OP_UNUSED, 8'd255, 8'd255);
        add_item(OP_CLEAR, 8'd0, 8'd0);
        add_typed_read(8'd254, 24'd0, 8'd254, 1'b1);
        // Inverted range: below lower goes to bin 0, above upper is dropped.
        // Bit 8 of the lower data must be ignored.
        add_write(CFG_LOWER, 9'h1C8);
        add_write(CFG_UPPER, 9'd50);
        add_item(OP_ADD, 8'd10,  8'd0);
        add_item(OP_ADD, 8'd60,  8'd0);
        add_item(OP_ADD, 8'd255, 8'd0);
        add_item(OP_READ, 8'd0, 8'd0);
        // Full range with a zero bin count, which behaves as a single bin.
        add_write(CFG_LOWER, 9'd0);
        add_write(CFG_UPPER, 9'd255);
        add_write(CFG_BINS, 9'd0);
        add_item(OP_ADD, 8'd200, 8'd0);
        add_item(OP_READ, 8'd0, 8'd0);
        add_typed_read(8'd1, 24'd0, 8'd0, 1'b0);
        // Bin counts at and past the store depth; a write to no register at all.
        add_write(CFG_BINS, 9'd256);
        add_item(OP_READ, 8'd0, 8'd255);
        add_write(CFG_BINS, 9'd511);
        add_write(CFG_NONE, 9'h1FF);
        add_item(OP_ADD, 8'd255, 8'd0);
        add_item(OP_READ, 8'd0, 8'd255);
    endfunction

    // ------------------------------------------------------------------
    // Random stimulus helpers.
    // ------------------------------------------------------------------

    // Range bound for a phase: the extremes often, otherwise anything.
    function automatic logic [8:0] pick_bound();
        logic [7:0] v;
        case ($urandom_range(3))
            0:       v = 8'd0;
            1:       v = 8'd255;
            default: v = $urandom_range(255);
        endcase
        return {1'($urandom_range(1)), v};
    endfunction

    // Bin count for a phase: the corner values, a few small counts, or anything.
    function automatic logic [8:0] pick_bins();
        case ($urandom_range(7))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd256;
            3:       return 9'd511;
            4:       return 9'd255;
            5:       return $urandom_range(16, 1);
            default: return $urandom_range(511);
        endcase
    endfunction

    // Pixel for an add: often right at or next to the range bounds, so that the
    // folding into the last bin and the drop above the range are hit often.
    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(5))
            0:       return shadow_lower + 8'($urandom_range(2)) - 8'd1;
            1:       return shadow_upper - 8'($urandom_range(2)) + 8'd1;
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic run_random_phase(input int phase);
        int unsigned pick;
        logic [1:0] code;
        logic [7:0] sel;
        logic [7:0] pix;
        if (phase == 0) begin
            write_reg(CFG_LOWER, 9'd0);
            write_reg(CFG_UPPER, 9'd255);
            write_reg(CFG_BINS, 9'd256);
        end else if (phase == 1) begin
            write_reg(CFG_LOWER, 9'd255);
            write_reg(CFG_UPPER, 9'd255);
            write_reg(CFG_BINS, 9'd1);
        end else begin
            write_reg(CFG_LOWER, pick_bound());
            write_reg(CFG_UPPER, pick_bound());
            write_reg(CFG_BINS, pick_bins());
            if ($urandom_range(1) == 1)
                write_reg(CFG_NONE, 9'($urandom_range(511)));
        end
        // One whole phase runs with no idle cycle on either side.
        calm = (phase == 2);
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            pix  = $urandom_range(255);
            sel  = $urandom_range(255);
            if (pick < 58) begin
                code = OP_ADD;
                pix  = pick_pixel();
            end else if (pick < 90) begin
                code = OP_READ;
                // Mostly bins in use, so that counts are seen, but also past the end.
                if ($urandom_range(3) != 0)
                    sel = $urandom_range(bins_in_use() - 1);
            end else if (pick < 95) begin
                code = OP_CLEAR;
            end else begin
                code = OP_UNUSED;
            end
            send_pixel_cmd(code, pix, sel, 1'b0, '0);
        end
        calm = 1'b0;
        let_block_settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed script, random phases, drain, verdict.
    // ------------------------------------------------------------------
    initial
    begin
        shadow_reset();
        build_script();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                let_block_settle();
                write_reg(script[i].code, script[i].value);
            end else begin
                send_pixel_cmd(script[i].code, script[i].value[7:0], script[i].bin_sel,
                               script[i].typed, script[i].want);
            end
        end
        let_block_settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
            run_random_phase(ph);

        // let_block_settle has already waited for every result and the tail latency.
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bph_pkg.sv
rtl/bph_cfg.sv
rtl/bph_front.sv
rtl/bph_queue.sv
rtl/bph_back.sv
rtl/binned_pixel_histogram_core.sv
tb/binned_pixel_histogram_core_tb.sv
